// ===== hdl/dprf_pkg.sv =====
// ----------------------------------------------------------------------------
// dprf_pkg
// shared types and constants of the display page refresh scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package dprf_pkg;

  // default panel geometry and retry interval after reset
  localparam int unsigned DPRF_PANEL_WIDTH = 128;
  localparam int unsigned DPRF_PAGE_COUNT  = 8;
  localparam logic [15:0] DPRF_RETRY_RESET = 16'd250;

  // item operation codes, codes 5 to 7 are unused
  typedef enum logic [2:0] {
    OP_PIXEL   = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_REFRESH = 3'd2,
    OP_FAIL    = 3'd3,
    OP_READ    = 3'd4
  } dprf_op_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [6:0]  x_coord;
    logic [5:0]  y_coord;
    logic        pixel_on;
    logic [2:0]  read_page;
    logic [31:0] now_ms;
  } dprf_in_t;

  typedef struct packed {
    logic        recover_bus;
    logic        send_valid;
    logic [2:0]  send_page;
    logic [7:0]  read_data;
    logic [31:0] fault_count;
    logic        bus_jammed;
  } dprf_out_t;

endpackage

`default_nettype wire

// ===== hdl/dprf_mem.sv =====
// ----------------------------------------------------------------------------
// dprf_mem
// byte memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dprf_mem import dprf_pkg::*; #(
  parameter int unsigned DEPTH = DPRF_PANEL_WIDTH * DPRF_PAGE_COUNT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/display_page_refresh_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// display_page_refresh_scheduler_core
// framebuffer with shadow copy, dirty page scan and fault / retry handling
// ----------------------------------------------------------------------------
//
//   channel  | signals                        | beat
//   ---------+--------------------------------+-------------------------------
//   in       | in_valid_i/in_ready_o/in_data_i   | one operation item
//   out      | out_valid_o/out_ready_i/out_data_o| one result per item
//   cfg      | cfg_we_i/cfg_data_i               | retry interval write
//
// refresh step: the single byte compare path walks each page one byte per cycle
// reset: a clearing pass writes zero to every frame byte, one per cycle,
//   and in_ready_o stays low
// one item at a time; in_ready_o is high only while the sequencer is idle,
//   a finished result sits in the output register until out_ready_i
// ----------------------------------------------------------------------------
`default_nettype none

module display_page_refresh_scheduler_core import dprf_pkg::*; #(
  parameter int unsigned PANEL_WIDTH = DPRF_PANEL_WIDTH,
  parameter int unsigned PAGE_COUNT  = DPRF_PAGE_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dprf_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dprf_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned DEPTH = PANEL_WIDTH * PAGE_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned CW    = $clog2(PANEL_WIDTH + 1);
  localparam int unsigned FW    = $clog2(PAGE_COUNT + 1);

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,  // zero sweep over the frame memory
    S_IDLE   = 9'b000000010,
    S_PIX_RD = 9'b000000100,  // read byte for pixel update
    S_PIX_WR = 9'b000001000,  // write back modified byte
    S_READ   = 9'b000010000,  // byte read for the transmitter
    S_REF    = 9'b000100000,  // retry check, start of refresh step
    S_CMP    = 9'b001000000,  // compare current page against shadow
    S_COPY   = 9'b010000000,  // copy current page into shadow
    S_DONE   = 9'b100000000   // load output register
  } state_e;

  // control state
  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            clr_item_q, clr_item_d;
  logic [PW-1:0]   next_page_q, next_page_d;
  logic [FW-1:0]   forced_q, forced_d;
  logic [31:0]     faults_q, faults_d;
  logic            jammed_q, jammed_d;
  logic [31:0]     retry_time_q, retry_time_d;
  logic [15:0]     retry_int_q, retry_int_d;
  logic            out_valid_q, out_valid_d;

  // working registers
  dprf_in_t        item_q, item_d;
  logic [CW-1:0]   col_q, col_d;
  logic [PW-1:0]   n_q, n_d;
  logic            pend_q, pend_d;
  logic            diff_q, diff_d;
  logic [AW-1:0]   cp_addr_q, cp_addr_d;
  logic            recover_q, recover_d;
  logic            send_valid_q, send_valid_d;
  logic [2:0]      send_page_q, send_page_d;
  logic            rd_hit_q, rd_hit_d;
  dprf_out_t       out_q, out_d;

  // memory ports
  logic            fr_we, fr_re, sh_we, sh_re;
  logic [AW-1:0]   fr_waddr, rd_addr_mux;
  logic [7:0]      fr_wdata, fr_rdata, sh_rdata;

  // address and compare path
  logic [AW-1:0]   pix_addr, byte_addr, page_addr;
  logic [7:0]      pix_mask;
  logic            issuing;
  logic            pix_ok_in, rd_ok_in;
  logic [PW-1:0]   np_inc;
  logic [31:0]     late;
  logic            load;

  assign pix_addr  = AW'(32'(item_q.y_coord[5:3]) * PANEL_WIDTH + 32'(item_q.x_coord));
  assign byte_addr = AW'(32'(item_q.read_page) * PANEL_WIDTH + 32'(item_q.x_coord));
  assign page_addr = AW'(32'(next_page_q) * PANEL_WIDTH + 32'(col_q));
  assign pix_mask  = 8'd1 << item_q.y_coord[2:0];

  // page walk still issuing reads
  assign issuing = (col_q != CW'(PANEL_WIDTH));

  assign pix_ok_in = (32'(in_data_i.x_coord) < PANEL_WIDTH) &&
                     (32'(in_data_i.y_coord[5:3]) < PAGE_COUNT);
  assign rd_ok_in  = (32'(in_data_i.x_coord) < PANEL_WIDTH) &&
                     (32'(in_data_i.read_page) < PAGE_COUNT);

  // round-robin page pointer step
  assign np_inc = (next_page_q == PW'(PAGE_COUNT - 1)) ? '0 : next_page_q + 1'b1;

  // sign of (now - retry time) says whether the retry time is reached
  assign late = item_q.now_ms - retry_time_q;

  assign load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memory port control
  always_comb begin
    fr_we       = 1'b0;
    fr_waddr    = pix_addr;
    fr_wdata    = 8'h00;
    fr_re       = 1'b0;
    sh_re       = 1'b0;
    sh_we       = 1'b0;
    rd_addr_mux = page_addr;
    case (state_q)
      S_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = clr_q;
      end
      S_PIX_RD: begin
        fr_re       = 1'b1;
        rd_addr_mux = pix_addr;
      end
      S_PIX_WR: begin
        fr_we    = 1'b1;
        fr_wdata = item_q.pixel_on ? (fr_rdata | pix_mask) : (fr_rdata & ~pix_mask);
      end
      S_READ: begin
        fr_re       = 1'b1;
        rd_addr_mux = byte_addr;
      end
      S_CMP: begin
        fr_re = issuing;
        sh_re = issuing;
      end
      S_COPY: begin
        fr_re = issuing;
        sh_we = pend_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_item_d   = clr_item_q;
    next_page_d  = next_page_q;
    forced_d     = forced_q;
    faults_d     = faults_q;
    jammed_d     = jammed_q;
    retry_time_d = retry_time_q;
    retry_int_d  = cfg_we_i ? cfg_data_i : retry_int_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    item_d       = item_q;
    col_d        = col_q;
    n_d          = n_q;
    pend_d       = pend_q;
    diff_d       = diff_q;
    cp_addr_d    = cp_addr_q;
    recover_d    = recover_q;
    send_valid_d = send_valid_q;
    send_page_d  = send_page_q;
    rd_hit_d     = rd_hit_q;
    out_d        = out_q;

    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d    = clr_item_q ? S_DONE : S_IDLE;
          clr_item_d = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_data_i;
          recover_d    = 1'b0;
          send_valid_d = 1'b0;
          send_page_d  = 3'd0;
          rd_hit_d     = 1'b0;
          case (in_data_i.operation)
            OP_PIXEL: begin
              state_d = pix_ok_in ? S_PIX_RD : S_DONE;
            end
            OP_CLEAR: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLEAR;
            end
            OP_REFRESH: begin
              state_d = S_REF;
            end
            OP_FAIL: begin
              faults_d     = faults_q + 32'd1;
              jammed_d     = 1'b1;
              retry_time_d = in_data_i.now_ms + {16'd0, retry_int_q};
              state_d      = S_DONE;
            end
            OP_READ: begin
              state_d = rd_ok_in ? S_READ : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_PIX_RD: begin
        state_d = S_PIX_WR;
      end

      S_PIX_WR: begin
        state_d = S_DONE;
      end

      S_READ: begin
        rd_hit_d = 1'b1;
        state_d  = S_DONE;
      end

      S_REF: begin
        if (jammed_q && late[31]) begin
          // still waiting for the retry time
          state_d = S_DONE;
        end else begin
          if (jammed_q) begin
            recover_d = 1'b1;
            jammed_d  = 1'b0;
            forced_d  = FW'(PAGE_COUNT);
          end
          n_d    = '0;
          col_d  = '0;
          pend_d = 1'b0;
          diff_d = 1'b0;
          // forced pages copy the current page without comparing
          state_d = (jammed_q || forced_q != '0) ? S_COPY : S_CMP;
        end
      end

      S_CMP: begin
        pend_d = issuing;
        if (issuing) begin
          col_d = col_q + 1'b1;
        end
        if (pend_q && (fr_rdata != sh_rdata)) begin
          diff_d = 1'b1;
        end
        if (!issuing && !pend_q) begin
          col_d = '0;
          if (diff_q) begin
            state_d = S_COPY;
          end else begin
            next_page_d = np_inc;
            diff_d      = 1'b0;
            if (n_q == PW'(PAGE_COUNT - 1)) begin
              // full lap, nothing changed
              state_d = S_DONE;
            end else begin
              n_d = n_q + 1'b1;
            end
          end
        end
      end

      S_COPY: begin
        pend_d    = issuing;
        cp_addr_d = page_addr;
        if (issuing) begin
          col_d = col_q + 1'b1;
        end
        if (!issuing && !pend_q) begin
          send_valid_d = 1'b1;
          send_page_d  = 3'(next_page_q);
          next_page_d  = np_inc;
          if (forced_q != '0) begin
            forced_d = forced_q - 1'b1;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (load) begin
          out_d.recover_bus = recover_q;
          out_d.send_valid  = send_valid_q;
          out_d.send_page   = send_page_q;
          out_d.read_data   = rd_hit_q ? fr_rdata : 8'h00;
          out_d.fault_count = faults_q;
          out_d.bus_jammed  = jammed_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      clr_item_q   <= 1'b0;
      next_page_q  <= '0;
      forced_q     <= FW'(PAGE_COUNT);
      faults_q     <= '0;
      jammed_q     <= 1'b0;
      retry_time_q <= '0;
      retry_int_q  <= DPRF_RETRY_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      clr_item_q   <= clr_item_d;
      next_page_q  <= next_page_d;
      forced_q     <= forced_d;
      faults_q     <= faults_d;
      jammed_q     <= jammed_d;
      retry_time_q <= retry_time_d;
      retry_int_q  <= retry_int_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    col_q        <= col_d;
    n_q          <= n_d;
    pend_q       <= pend_d;
    diff_q       <= diff_d;
    cp_addr_q    <= cp_addr_d;
    recover_q    <= recover_d;
    send_valid_q <= send_valid_d;
    send_page_q  <= send_page_d;
    rd_hit_q     <= rd_hit_d;
    out_q        <= out_d;
  end

  // frame buffer
  dprf_mem #(
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (rd_addr_mux),
    .rdata_o (fr_rdata)
  );

  // shadow of what the panel shows, written at the registered read address with frame read data
  dprf_mem #(
    .DEPTH (DEPTH)
  ) u_shown (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (cp_addr_q),
    .wdata_i (fr_rdata),
    .re_i    (sh_re),
    .raddr_i (rd_addr_mux),
    .rdata_o (sh_rdata)
  );

`ifndef SYNTHESIS
  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat without finished item");

  a_shadow_write_in_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_we |-> $past(state_q == S_COPY))
    else $error("shadow written outside page copy");

  a_forced_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    forced_q <= FW'(PAGE_COUNT))
    else $error("forced page count out of range");

  a_send_only_on_refresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (item_q.operation != OP_REFRESH) |->
      !send_valid_q && !recover_q)
    else $error("send or recovery flagged on non-refresh item");

  a_one_item_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while item in progress");
`endif

endmodule

`default_nettype wire
